// ===== hw/rtl/lkv_pkg.sv =====
// shared constants, request codes and cell bus types for the lru-k victim selector
// no dependencies
package lkv_pkg;

  localparam int FRAME_SLOTS = 64;
  localparam int K_MAX       = 4;
  localparam int TIME_BITS   = 32;
  localparam int FRAME_W     = $clog2(FRAME_SLOTS);
  localparam int FILL_W      = $clog2(K_MAX + 1);
  localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);
  localparam int DEPTH_W     = 3;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_SET    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_EVICT  = 2'd3;

  // request broadcast to every cell
  typedef struct packed {
    logic                 valid;
    logic [1:0]           kind;
    logic [FRAME_W-1:0]   frame;
    logic                 value;
    logic [TIME_BITS-1:0] stamp;
    logic [FILL_W-1:0]    depth;
  } cmd_t;

  // best candidate handed from cell to cell during a scan
  typedef struct packed {
    logic                 go;
    logic                 found;
    logic                 inf;
    logic [TIME_BITS-1:0] key;
    logic [TIME_BITS-1:0] old;
    logic [FRAME_W-1:0]   idx;
  } best_t;

endpackage

// ===== hw/rtl/lkv_cell.sv =====
// one frame slot: tracking flags, access history and one compare stage of the scan
// depends on lkv_pkg
module lkv_cell import lkv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [FRAME_W-1:0] cell_id,
  input  cmd_t               cmd,
  input  best_t              best_in,
  output best_t              best_out,
  output logic               tracked_o,
  output logic               evict_o
);

  logic                 tracked_r, tracked_nxt;
  logic                 ev_r, ev_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [TIME_BITS-1:0] hist_r [K_MAX];
  logic [TIME_BITS-1:0] hist_nxt [K_MAX];
  best_t                best_r, best_nxt;

  logic                 hit;
  logic [FILL_W-1:0]    fb, n, d, j;
  logic [TIME_BITS-1:0] a [K_MAX+1];
  logic                 elig, inf, better;
  logic [FILL_W-1:0]    kidx;
  logic [TIME_BITS-1:0] key;

  assign hit = cmd.valid && (cmd.frame == cell_id);

  // request handling, history append and trim
  always_comb begin
    tracked_nxt = tracked_r;
    ev_nxt      = ev_r;
    fill_nxt    = fill_r;
    hist_nxt    = hist_r;
    fb = tracked_r ? fill_r : '0;
    for (int i = 0; i < K_MAX; i++) begin
      a[i] = (FILL_W'(i) < fb) ? hist_r[i] : cmd.stamp;
    end
    a[K_MAX] = cmd.stamp;
    n = fb + FILL_W'(1);
    d = (n > cmd.depth) ? (n - cmd.depth) : '0;
    if (hit) begin
      case (cmd.kind)
        KIND_RECORD: begin
          if (!tracked_r) ev_nxt = 1'b0;
          tracked_nxt = 1'b1;
          fill_nxt    = n - d;
          for (int i = 0; i < K_MAX; i++) begin
            j = FILL_W'(i) + d;
            hist_nxt[i] = (j <= FILL_W'(K_MAX)) ? a[j] : '0;
          end
        end
        KIND_SET: begin
          if (tracked_r) ev_nxt = cmd.value;
        end
        KIND_REMOVE: begin
          if (tracked_r && ev_r) begin
            tracked_nxt = 1'b0;
            ev_nxt      = 1'b0;
            fill_nxt    = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // compare own key with the incoming best
  always_comb begin
    elig = tracked_r && ev_r && (fill_r != '0);
    inf  = fill_r < cmd.depth;
    kidx = fill_r - cmd.depth;
    key  = inf ? hist_r[0] : hist_r[kidx[FILL_W-2:0]];
    if (!best_in.found)        better = 1'b1;
    else if (inf != best_in.inf) better = inf;
    else if (key != best_in.key) better = key < best_in.key;
    else                         better = hist_r[0] < best_in.old;
    best_nxt = best_in;
    if (elig && better) begin
      best_nxt.found = 1'b1;
      best_nxt.inf   = inf;
      best_nxt.key   = key;
      best_nxt.old   = hist_r[0];
      best_nxt.idx   = cell_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r   <= 1'b0;
      ev_r        <= 1'b0;
      fill_r      <= '0;
      best_r      <= '0;
    end else begin
      tracked_r   <= tracked_nxt;
      ev_r        <= ev_nxt;
      fill_r      <= fill_nxt;
      best_r      <= best_nxt;
    end
  end

  // history payload
  always_ff @(posedge clk) begin
    hist_r        <= hist_nxt;
  end

  assign best_out  = best_r;
  assign tracked_o = tracked_r;
  assign evict_o   = ev_r;

endmodule

// ===== hw/rtl/lru_k_victim_selector.sv =====
// lru-k victim selector top level: request control, counters and the row of frame cells
// depends on lkv_pkg and lkv_cell
//
// usage:
//   requests enter on in_valid/in_ready with in_kind, in_frame, in_evictable_value.
//   each item gives exactly one result on out_valid/out_ready carrying
//   out_victim_found, out_victim_frame and out_evictable_total.
//   record, set and remove items: result is registered in the cycle after accept.
//   evict items: the candidate travels through the row of 64 cells, one cell a
//   cycle, and the result is registered once it leaves the last cell; no item is
//   taken meanwhile. throughput is one item per cycle for non-evict requests while
//   the receiver keeps up; an evict item holds off new items until its scan is through.
//   cfg_wr_en/cfg_wr_data write k (history depth); the user must write it only while
//   idle, the block does not enforce it; 0 acts as 1, values above 4 act as 4.
//   reset (rst_n low, synchronous) untracks every frame, clears the access
//   counter and the evictable count and sets k to 2.
//   when the receiver stalls the result waits in the output register and a new
//   item is taken only in the cycle the waiting result leaves.
module lru_k_victim_selector import lkv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [FRAME_W-1:0] in_frame,
  input  logic               in_evictable_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_victim_found,
  output logic [FRAME_W-1:0] out_victim_frame,
  output logic [CNT_W-1:0]   out_evictable_total,
  input  logic               cfg_wr_en,
  input  logic [DEPTH_W-1:0] cfg_wr_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state_r, state_nxt;
  logic [DEPTH_W-1:0]   depth_r;
  logic [TIME_BITS-1:0] clock_r, clock_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 found_r, found_nxt;
  logic [FRAME_W-1:0]   victim_r, victim_nxt;
  logic [FILL_W-1:0]    k_eff;
  logic                 accept, scan_done;
  cmd_t                 cmd;
  best_t                scan_in;
  best_t                chain [FRAME_SLOTS+1];
  logic [FRAME_SLOTS-1:0] trk_vec, ev_vec;

  // effective history depth
  always_comb begin
    if (depth_r == '0)                          k_eff = FILL_W'(1);
    else if (depth_r > DEPTH_W'(K_MAX))         k_eff = FILL_W'(K_MAX);
    else                                        k_eff = FILL_W'(depth_r);
  end

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign scan_done = (state_r == ST_SCAN) && chain[FRAME_SLOTS].go;

  // scan entry token
  always_comb begin
    scan_in    = '0;
    scan_in.go = accept && (in_kind == KIND_EVICT);
  end

  assign chain[0] = scan_in;

  // row of frame cells
  for (genvar g = 0; g < FRAME_SLOTS; g++) begin : g_cell
    lkv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_id   (FRAME_W'(g)),
      .cmd       (cmd),
      .best_in   (chain[g]),
      .best_out  (chain[g+1]),
      .tracked_o (trk_vec[g]),
      .evict_o   (ev_vec[g])
    );
  end

  // request control and counters
  always_comb begin
    state_nxt     = state_r;
    clock_nxt     = clock_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    found_nxt     = found_r;
    victim_nxt    = victim_r;
    cmd           = '0;
    cmd.depth     = k_eff;
    cmd.stamp     = clock_r;
    if (accept && in_kind != KIND_EVICT) begin
      cmd.valid  = 1'b1;
      cmd.kind   = in_kind;
      cmd.frame  = in_frame;
      cmd.value  = in_evictable_value;
      case (in_kind)
        KIND_RECORD: begin
          if (clock_r != '1) clock_nxt = clock_r + TIME_BITS'(1);
        end
        KIND_SET: begin
          if (trk_vec[in_frame]) begin
            if (ev_vec[in_frame] && !in_evictable_value && cnt_r != '0)
              cnt_nxt = cnt_r - CNT_W'(1);
            else if (!ev_vec[in_frame] && in_evictable_value)
              cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        KIND_REMOVE: begin
          if (trk_vec[in_frame] && ev_vec[in_frame] && cnt_r != '0)
            cnt_nxt = cnt_r - CNT_W'(1);
        end
        default: ;
      endcase
      out_valid_nxt = 1'b1;
      found_nxt     = 1'b0;
      victim_nxt    = '0;
    end else if (accept) begin
      state_nxt = ST_SCAN;
    end
    if (scan_done) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      found_nxt     = chain[FRAME_SLOTS].found;
      victim_nxt    = chain[FRAME_SLOTS].found ? chain[FRAME_SLOTS].idx : '0;
      if (chain[FRAME_SLOTS].found) begin
        cmd.valid = 1'b1;
        cmd.kind  = KIND_REMOVE;
        cmd.frame = chain[FRAME_SLOTS].idx;
        if (cnt_r != '0) cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= DEPTH_W'(2);
      clock_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) depth_r <= cfg_wr_data;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    victim_r <= victim_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_victim_found    = found_r;
  assign out_victim_frame    = victim_r;
  assign out_evictable_total = cnt_r;

  // evictable count matches the cell flags
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ev_vec) == 32'(cnt_r))
    else $error("evictable count out of step with cell flags");

  // no item is taken while a scan runs
  a_scan_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !in_ready)
    else $error("item accepted during scan");

  // an evictable flag is only held by a tracked frame
  a_ev_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_vec & ~trk_vec) == '0)
    else $error("untracked frame marked evictable");

endmodule

// ===== dv/lkv_checker.sv =====
// result checker for the lru-k victim selector: follows both channels and the depth register
// keeps its own table of frames, predicts every result and counts mismatches; needs lkv_pkg
`timescale 1ns / 100ps

module lkv_checker import lkv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [FRAME_W-1:0] in_frame,
  input  logic               in_evictable_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_victim_found,
  input  logic [FRAME_W-1:0] out_victim_frame,
  input  logic [CNT_W-1:0]   out_evictable_total,
  input  logic               cfg_wr_en,
  input  logic [DEPTH_W-1:0] cfg_wr_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   total;
  } victim_res_t;

  // mirror of the frame table
  logic                 is_tracked [FRAME_SLOTS];
  logic                 is_evictable [FRAME_SLOTS];
  int                   fill_cnt [FRAME_SLOTS];
  logic [TIME_BITS-1:0] stamp_hist [FRAME_SLOTS][K_MAX];
  logic [TIME_BITS-1:0] access_clock;
  int                   evictable_cnt;
  logic [DEPTH_W-1:0]   depth_reg;

  victim_res_t expected_results[$];

  function automatic int active_depth();
    if (depth_reg == 0) return 1;
    if (depth_reg > K_MAX) return K_MAX;
    return int'(depth_reg);
  endfunction

  function automatic void shift_out_oldest(int f);
    for (int i = 1; i < fill_cnt[f]; i++) stamp_hist[f][i-1] = stamp_hist[f][i];
    if (fill_cnt[f] > 0) fill_cnt[f]--;
  endfunction

  function automatic void note_access(int f);
    int k;
    k = active_depth();
    if (!is_tracked[f]) begin
      is_tracked[f] = 1'b1;
      is_evictable[f] = 1'b0;
      fill_cnt[f] = 0;
    end
    if (fill_cnt[f] >= K_MAX) shift_out_oldest(f);
    stamp_hist[f][fill_cnt[f]] = access_clock;
    fill_cnt[f]++;
    while (fill_cnt[f] > k) shift_out_oldest(f);
    if (access_clock != '1) access_clock++;
  endfunction

  // scan for the victim: infinite distance first, then oldest k-th access
  function automatic victim_res_t pick_victim();
    victim_res_t r;
    int k, best;
    logic found, best_inf, inf, better;
    logic [TIME_BITS-1:0] best_key, best_old, key, old;
    k = active_depth();
    found = 0; best_inf = 0; best_key = 0; best_old = 0; best = 0;
    for (int f = 0; f < FRAME_SLOTS; f++) begin
      if (!is_tracked[f] || !is_evictable[f] || fill_cnt[f] == 0) continue;
      inf = fill_cnt[f] < k;
      old = stamp_hist[f][0];
      key = inf ? old : stamp_hist[f][fill_cnt[f] - k];
      if (!found) better = 1;
      else if (inf != best_inf) better = inf;
      else if (key != best_key) better = key < best_key;
      else better = old < best_old;
      if (better) begin
        found = 1; best_inf = inf; best_key = key; best_old = old; best = f;
      end
    end
    r.found = found;
    r.frame = found ? FRAME_W'(best) : '0;
    if (found) begin
      is_tracked[best] = 0;
      is_evictable[best] = 0;
      fill_cnt[best] = 0;
      if (evictable_cnt > 0) evictable_cnt--;
    end
    return r;
  endfunction

  function automatic victim_res_t apply_request(logic [1:0] kind, int f, logic val);
    victim_res_t r;
    r = '0;
    case (kind)
      KIND_EVICT: r = pick_victim();
      KIND_RECORD: note_access(f);
      KIND_SET: begin
        if (is_tracked[f]) begin
          if (is_evictable[f] && !val) begin
            is_evictable[f] = 0;
            if (evictable_cnt > 0) evictable_cnt--;
          end else if (!is_evictable[f] && val) begin
            is_evictable[f] = 1;
            evictable_cnt++;
          end
        end
      end
      default: begin
        if (is_tracked[f] && is_evictable[f]) begin
          is_tracked[f] = 0;
          is_evictable[f] = 0;
          fill_cnt[f] = 0;
          if (evictable_cnt > 0) evictable_cnt--;
        end
      end
    endcase
    r.total = CNT_W'(evictable_cnt);
    return r;
  endfunction

  // watch the channels at every rising edge
  always @(posedge clk) begin
    victim_res_t want, got;
    if (!rst_n) begin
      for (int f = 0; f < FRAME_SLOTS; f++) begin
        is_tracked[f] = 0;
        is_evictable[f] = 0;
        fill_cnt[f] = 0;
      end
      access_clock = 0;
      evictable_cnt = 0;
      depth_reg = 3'd2;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) depth_reg = cfg_wr_data;
      if (out_valid && out_ready) begin
        got = '{out_victim_found, out_victim_frame, out_evictable_total};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected found=%0d frame=%0d total=%0d, got %0d %0d %0d",
                       want.found, want.frame, want.total,
                       got.found, got.frame, got.total);
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(),
                                apply_request(in_kind, in_frame, in_evictable_value));
    end
    pending = expected_results.size();
  end

endmodule

// ===== dv/lru_k_victim_selector_tb.sv =====
// top of the lru-k victim selector testbench: clock, reset, request stimulus and verdict
// depends on lkv_pkg, lkv_checker and the lru_k_victim_selector rtl
`timescale 1ns / 100ps

module lru_k_victim_selector_tb import lkv_pkg::*;;

  localparam int CYCLE_LIMIT = 1000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_kind;
  logic [FRAME_W-1:0] in_frame;
  logic               in_evictable_value;
  logic               out_valid;
  logic               out_ready;
  logic               out_victim_found;
  logic [FRAME_W-1:0] out_victim_frame;
  logic [CNT_W-1:0]   out_evictable_total;
  logic               cfg_wr_en;
  logic [DEPTH_W-1:0] cfg_wr_data;
  int                 fail_count;
  int                 pending;
  int                 cycle_cnt = 0;
  int                 hold_cnt;
  logic               quiet_mode;

  lru_k_victim_selector dut (.*);

  lkv_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cnt != holds_done) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        holds_done++;
      end else begin
        int stall;
        stall = quiet_mode ? 0 : $urandom_range(0, 14);
        if (stall > 0) begin
          out_ready <= 0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1;
        do @(posedge clk); while (!(out_valid && out_ready));
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [FRAME_W-1:0] f, logic val);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_frame <= f;
    in_evictable_value <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // pause the sender until every result has come, then write k
  task automatic set_depth(logic [DEPTH_W-1:0] d);
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  // mostly a small hot set of frames so the table sees reuse
  task automatic random_items(int count, int hot_base);
    logic [1:0] kind;
    logic [FRAME_W-1:0] f;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (($urandom_range(0, 99) < 15)) quiet_mode = ~quiet_mode & ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = KIND_RECORD;
      else if (pick < 65) kind = KIND_SET;
      else if (pick < 75) kind = KIND_REMOVE;
      else kind = KIND_EVICT;
      if ($urandom_range(0, 9) < 7) f = FRAME_W'(hot_base + $urandom_range(0, 9));
      else f = FRAME_W'($urandom_range(0, FRAME_SLOTS - 1));
      send_item(kind, f, $urandom_range(0, 9) < 7);
    end
  endtask

  initial begin
    logic [DEPTH_W-1:0] depth_plan [8];
    depth_plan = '{3'd2, 3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2};
    rst_n = 0;
    in_valid = 0;
    in_kind = KIND_RECORD;
    in_frame = 0;
    in_evictable_value = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    hold_cnt = 0;
    quiet_mode = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty evict, untracked frames, ties on short histories
    send_item(KIND_EVICT, 6'd0, 0);
    send_item(KIND_SET, 6'd63, 1);
    send_item(KIND_REMOVE, 6'd63, 1);
    send_item(KIND_RECORD, 6'd63, 0);
    send_item(KIND_RECORD, 6'd0, 0);
    send_item(KIND_REMOVE, 6'd0, 1);
    send_item(KIND_RECORD, 6'd0, 0);
    send_item(KIND_RECORD, 6'd21, 0);
    send_item(KIND_RECORD, 6'd42, 1);
    send_item(KIND_RECORD, 6'd42, 0);
    send_item(KIND_SET, 6'd63, 1);
    send_item(KIND_SET, 6'd0, 1);
    send_item(KIND_SET, 6'd42, 1);
    send_item(KIND_SET, 6'd21, 1);
    send_item(KIND_SET, 6'd21, 0);
    send_item(KIND_SET, 6'd21, 1);
    send_item(KIND_EVICT, 6'd63, 1);
    send_item(KIND_EVICT, 6'd0, 0);
    send_item(KIND_REMOVE, 6'd21, 0);
    send_item(KIND_EVICT, 6'd0, 0);
    send_item(KIND_EVICT, 6'd0, 0);

    for (int p = 0; p < 8; p++) begin
      set_depth(depth_plan[p]);
      if (p == 0) hold_cnt++;
      if (p == 2) begin
        // fill the whole table evictable, then drain part of it
        for (int f = 0; f < FRAME_SLOTS; f++) send_item(KIND_RECORD, FRAME_W'(f), 0);
        for (int f = 0; f < FRAME_SLOTS; f++) send_item(KIND_SET, FRAME_W'(f), 1);
        for (int f = 0; f < 10; f++) send_item(KIND_EVICT, 6'd0, 0);
      end
      random_items(200, $urandom_range(0, FRAME_SLOTS - 10));
    end
    quiet_mode = 0;

    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
